// ===== rtl/qstm_pkg.sv =====
`default_nettype none
package qstm_pkg;

  localparam int unsigned QuatW  = 16;
  localparam int unsigned ScaleW = 16;
  localparam int unsigned TransW = 32;
  localparam int unsigned OutW   = 32;

  // Product of two quaternion components.
  localparam int unsigned ProdW = 2 * QuatW;
  // A bracketed term in Q.28 spans roughly plus or minus 2^32.
  localparam int unsigned TermW = ProdW + 2;
  // Term times scale, in Q.36.
  localparam int unsigned MulW = TermW + ScaleW;
  localparam int unsigned FracShift = 20;
  localparam int unsigned RndW = MulW - FracShift;

  localparam logic signed [TermW-1:0] TermOne = TermW'(64'sd1 <<< 28);
  localparam logic signed [MulW-1:0]  RndHalf = MulW'(64'sd1 <<< (FracShift - 1));

  localparam logic signed [OutW-1:0] OutMax = {1'b0, {(OutW-1){1'b1}}};
  localparam logic signed [OutW-1:0] OutMin = {1'b1, {(OutW-1){1'b0}}};

endpackage
`default_nettype wire

// ===== rtl/qstm_entry.sv =====
`default_nettype none
module qstm_entry
  import qstm_pkg::*;
(
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     valid_i,
  input  wire logic signed [TermW-1:0]  term_i,
  input  wire logic signed [ScaleW-1:0] scale_i,
  output logic                          valid_o,
  output logic signed [OutW-1:0]        result_o
);

  logic                   mul_vld_q;
  logic signed [MulW-1:0] mul_d, mul_q;
  logic signed [MulW-1:0] rnd_sum;
  logic signed [RndW-1:0] rnd_val;
  logic signed [OutW-1:0] res_d, res_q;
  logic                   res_vld_q;

  assign mul_d = MulW'(term_i) * MulW'(scale_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_vld_q <= 1'b0;
      res_vld_q <= 1'b0;
    end else begin
      mul_vld_q <= valid_i;
      res_vld_q <= mul_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    mul_q <= mul_d;
    res_q <= res_d;
  end

  // Round half up, then take the floor of the division by 2^20.
  assign rnd_sum = mul_q + RndHalf;
  assign rnd_val = rnd_sum[MulW-1:FracShift];

  always_comb begin
    if (RndW > OutW) begin
      if (rnd_val > RndW'(OutMax)) begin
        res_d = OutMax;
      end else if (rnd_val < RndW'(OutMin)) begin
        res_d = OutMin;
      end else begin
        res_d = OutW'(rnd_val);
      end
    end else begin
      res_d = OutW'(rnd_val);
    end
  end

  assign valid_o  = res_vld_q;
  assign result_o = res_q;

endmodule
`default_nettype wire

// ===== rtl/quaternion_scale_translate_matrix.sv =====
`default_nettype none
// Scaled rotation matrix from a quaternion, with translation passed alongside.
// Input: a request is taken at each rising edge with start_i high and busy_o
// low. busy_o is always low, so a new request may be given in every cycle.
// Output: done_o is high for exactly one cycle with the nine matrix entries
// r00_o to r22_o and the translation out_tx_o to out_tz_o; the receiver must
// take them in that cycle.
// Throughput is one request per cycle. The four register stages are the
// component products, the bracketed terms, the term times scale
// multiplication, and the rounding of each entry to Q16.16.
// Requests leave in the order in which they were taken.
// Reset clears all valid bits in the pipeline, so no result appears until a
// request has been accepted; data registers are not reset.
// The receiver cannot stall, so the pipeline never holds.
module quaternion_scale_translate_matrix
  import qstm_pkg::*;
(
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     start_i,
  output logic                          busy_o,
  input  wire logic signed [QuatW-1:0]  quat_x_i,
  input  wire logic signed [QuatW-1:0]  quat_y_i,
  input  wire logic signed [QuatW-1:0]  quat_z_i,
  input  wire logic signed [QuatW-1:0]  quat_w_i,
  input  wire logic signed [ScaleW-1:0] scale_x_i,
  input  wire logic signed [ScaleW-1:0] scale_y_i,
  input  wire logic signed [ScaleW-1:0] scale_z_i,
  input  wire logic signed [TransW-1:0] trans_x_i,
  input  wire logic signed [TransW-1:0] trans_y_i,
  input  wire logic signed [TransW-1:0] trans_z_i,
  output logic                          done_o,
  output logic signed [OutW-1:0]        r00_o,
  output logic signed [OutW-1:0]        r01_o,
  output logic signed [OutW-1:0]        r02_o,
  output logic signed [OutW-1:0]        r10_o,
  output logic signed [OutW-1:0]        r11_o,
  output logic signed [OutW-1:0]        r12_o,
  output logic signed [OutW-1:0]        r20_o,
  output logic signed [OutW-1:0]        r21_o,
  output logic signed [OutW-1:0]        r22_o,
  output logic signed [TransW-1:0]      out_tx_o,
  output logic signed [TransW-1:0]      out_ty_o,
  output logic signed [TransW-1:0]      out_tz_o
);

  function automatic logic signed [TermW-1:0] dbl(input logic signed [ProdW-1:0] p);
    dbl = {p[ProdW-1], p, 1'b0};
  endfunction

  logic req;
  assign busy_o = 1'b0;
  assign req    = start_i && !busy_o;

  // Stage one: component products.
  logic                    v1_q;
  logic signed [ProdW-1:0] xx_q, yy_q, zz_q, xy_q, yz_q, xz_q, xw_q, yw_q, zw_q;
  logic signed [ScaleW-1:0] sx1_q, sy1_q, sz1_q;
  logic signed [TransW-1:0] tx1_q, ty1_q, tz1_q;

  // Stage two: bracketed terms in Q.28.
  logic                     v2_q;
  logic signed [TermW-1:0]  t00_q, t01_q, t02_q, t10_q, t11_q, t12_q, t20_q, t21_q, t22_q;
  logic signed [ScaleW-1:0] sx2_q, sy2_q, sz2_q;
  logic signed [TransW-1:0] tx2_q, ty2_q, tz2_q;

  // Translation waits for the two stages inside the entry units.
  logic signed [TransW-1:0] tx3_q, ty3_q, tz3_q, tx4_q, ty4_q, tz4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= req;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    xx_q  <= ProdW'(quat_x_i) * ProdW'(quat_x_i);
    yy_q  <= ProdW'(quat_y_i) * ProdW'(quat_y_i);
    zz_q  <= ProdW'(quat_z_i) * ProdW'(quat_z_i);
    xy_q  <= ProdW'(quat_x_i) * ProdW'(quat_y_i);
    yz_q  <= ProdW'(quat_y_i) * ProdW'(quat_z_i);
    xz_q  <= ProdW'(quat_x_i) * ProdW'(quat_z_i);
    xw_q  <= ProdW'(quat_x_i) * ProdW'(quat_w_i);
    yw_q  <= ProdW'(quat_y_i) * ProdW'(quat_w_i);
    zw_q  <= ProdW'(quat_z_i) * ProdW'(quat_w_i);
    sx1_q <= scale_x_i;
    sy1_q <= scale_y_i;
    sz1_q <= scale_z_i;
    tx1_q <= trans_x_i;
    ty1_q <= trans_y_i;
    tz1_q <= trans_z_i;

    t00_q <= TermOne - dbl(yy_q) - dbl(zz_q);
    t01_q <= dbl(xy_q) - dbl(zw_q);
    t02_q <= dbl(xz_q) + dbl(yw_q);
    t10_q <= dbl(xy_q) + dbl(zw_q);
    t11_q <= TermOne - dbl(xx_q) - dbl(zz_q);
    t12_q <= dbl(yz_q) - dbl(xw_q);
    t20_q <= dbl(xz_q) - dbl(yw_q);
    t21_q <= dbl(yz_q) + dbl(xw_q);
    t22_q <= TermOne - dbl(xx_q) - dbl(yy_q);
    sx2_q <= sx1_q;
    sy2_q <= sy1_q;
    sz2_q <= sz1_q;
    tx2_q <= tx1_q;
    ty2_q <= ty1_q;
    tz2_q <= tz1_q;

    tx3_q <= tx2_q;
    ty3_q <= ty2_q;
    tz3_q <= tz2_q;
    tx4_q <= tx3_q;
    ty4_q <= ty3_q;
    tz4_q <= tz3_q;
  end

  logic [8:0] ent_vld;

  qstm_entry u_e00 (.clk_i, .rst_ni, .valid_i(v2_q), .term_i(t00_q), .scale_i(sx2_q),
                    .valid_o(ent_vld[0]), .result_o(r00_o));
  qstm_entry u_e01 (.clk_i, .rst_ni, .valid_i(v2_q), .term_i(t01_q), .scale_i(sy2_q),
                    .valid_o(ent_vld[1]), .result_o(r01_o));
  qstm_entry u_e02 (.clk_i, .rst_ni, .valid_i(v2_q), .term_i(t02_q), .scale_i(sz2_q),
                    .valid_o(ent_vld[2]), .result_o(r02_o));
  qstm_entry u_e10 (.clk_i, .rst_ni, .valid_i(v2_q), .term_i(t10_q), .scale_i(sx2_q),
                    .valid_o(ent_vld[3]), .result_o(r10_o));
  qstm_entry u_e11 (.clk_i, .rst_ni, .valid_i(v2_q), .term_i(t11_q), .scale_i(sy2_q),
                    .valid_o(ent_vld[4]), .result_o(r11_o));
  qstm_entry u_e12 (.clk_i, .rst_ni, .valid_i(v2_q), .term_i(t12_q), .scale_i(sz2_q),
                    .valid_o(ent_vld[5]), .result_o(r12_o));
  qstm_entry u_e20 (.clk_i, .rst_ni, .valid_i(v2_q), .term_i(t20_q), .scale_i(sx2_q),
                    .valid_o(ent_vld[6]), .result_o(r20_o));
  qstm_entry u_e21 (.clk_i, .rst_ni, .valid_i(v2_q), .term_i(t21_q), .scale_i(sy2_q),
                    .valid_o(ent_vld[7]), .result_o(r21_o));
  qstm_entry u_e22 (.clk_i, .rst_ni, .valid_i(v2_q), .term_i(t22_q), .scale_i(sz2_q),
                    .valid_o(ent_vld[8]), .result_o(r22_o));

  assign done_o   = &ent_vld;
  assign out_tx_o = tx4_q;
  assign out_ty_o = ty4_q;
  assign out_tz_o = tz4_q;

`ifndef NO_ASSERTIONS
  a_done_follows_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i, 4))
    else $error("result without a request four cycles earlier");

  a_units_agree: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (|ent_vld) |-> (&ent_vld))
    else $error("matrix entry units out of step");

  a_trans_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (out_tx_o == $past(trans_x_i, 4)))
    else $error("translation not aligned with its request");

  a_zero_scale: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && $past(scale_x_i == '0, 4)) |-> (r00_o == '0 && r10_o == '0 && r20_o == '0))
    else $error("zero x scale gives a non-zero first column");
`endif

endmodule
`default_nettype wire
